[hw/rtl/rlrt_pkg.sv]
// Package for the replicated log ring table: action and status codes,
// payload structs for both channels and the queue entry between front and back.
// No dependencies.
package rlrt_pkg;

  localparam int unsigned DEF_LOG_DEPTH     = 1024;
  localparam int unsigned DEF_PAYLOAD_WIDTH = 32;
  localparam int unsigned DEF_VOTE_WIDTH    = 8;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_TRUNC  = 3'd2;
  localparam logic [2:0] ACT_POP    = 3'd3;
  localparam logic [2:0] ACT_PEEK   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;
  localparam logic [2:0] ACT_VOTE   = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO_ID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] log_index;
    logic [31:0] new_id;
    logic [31:0] new_payload;
  } rlrt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_id;
    logic [31:0] out_payload;
    logic [7:0]  out_votes;
    logic [10:0] entries_held;
    logic [31:0] base_now;
  } rlrt_out_t;

  typedef struct packed {
    rlrt_in_t req;
    logic     id_zero;
  } rlrt_cmd_t;

endpackage

[hw/rtl/replicated_log_ring_table_unit.sv]
// A request is queued in the front, read from the entry memories by the back end,
// then executed, and its result is registered. The back end takes no new command
// until its execute and write-back step fires; a two-entry queue decouples the front.
// Reset clears pointers, fill count, base and the queue; entry memories are not
// cleared and hold whatever they held until appended.
module replicated_log_ring_table_unit import rlrt_pkg::*; #(
  parameter int unsigned LOG_DEPTH     = DEF_LOG_DEPTH,
  parameter int unsigned PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH,
  parameter int unsigned VOTE_WIDTH    = DEF_VOTE_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rlrt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rlrt_out_t out_data_o
);

  logic      cmd_valid, cmd_ready;
  rlrt_cmd_t cmd;

  rlrt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rlrt_back #(
    .LOG_DEPTH     (LOG_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .VOTE_WIDTH    (VOTE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/rlrt_front.sv]
// Front end of the log ring table: accepts requests, flags a zero id and
// queues the classified command for the back end. Depends on rlrt_pkg.
module rlrt_front import rlrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rlrt_in_t  in_data_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output rlrt_cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);

  rlrt_cmd_t       slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;
  rlrt_cmd_t       new_cmd;

  assign in_ready_o  = cnt_q != CntW'(QUEUE_DEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    new_cmd.req     = in_data_i;
    new_cmd.id_zero = in_data_i.new_id == '0;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/rlrt_back.sv]
// Back end of the log ring table: ring pointers, entry memories and the
// two-step execute sequence with the result register. Depends on rlrt_pkg.
module rlrt_back import rlrt_pkg::*; #(
  parameter int unsigned LOG_DEPTH     = DEF_LOG_DEPTH,
  parameter int unsigned PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH,
  parameter int unsigned VOTE_WIDTH    = DEF_VOTE_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  rlrt_cmd_t cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rlrt_out_t out_data_o
);

  localparam int unsigned AddrW = $clog2(LOG_DEPTH);
  localparam int unsigned CntW  = $clog2(LOG_DEPTH + 1);
  localparam logic [AddrW-1:0] LastPos = AddrW'(LOG_DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt = CntW'(LOG_DEPTH);
  localparam logic [CntW:0]    WrapSum = (CntW + 1)'(LOG_DEPTH);
  localparam logic [VOTE_WIDTH-1:0] VoteMax = '1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q;

  // Ring state
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [31:0]      base_q, base_d;

  // Entry memories
  logic [31:0]              id_mem   [LOG_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_mem  [LOG_DEPTH];
  logic [VOTE_WIDTH-1:0]    vote_mem [LOG_DEPTH];
  logic [31:0]              rd_id_q;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_q;
  logic [VOTE_WIDTH-1:0]    rd_vote_q;

  // Command captured for the execute step
  rlrt_cmd_t        cmd_q;
  logic             hit_q;
  logic [CntW-1:0]  keep_q;
  logic [AddrW-1:0] loc_q;

  rlrt_out_t out_q, res;
  logic      out_valid_q;

  logic             take, fire;
  logic             above_base, in_range;
  logic [31:0]      rel_idx;
  logic [CntW-1:0]  keep;
  logic [CntW:0]    loc_sum, loc_wrap;
  logic [AddrW-1:0] loc_pos, peek_pos, rd_addr, head_inc, tail_inc;
  logic             app_we, vote_we;
  logic [AddrW-1:0] vote_wa;
  logic [VOTE_WIDTH-1:0] vote_wd, vote_inc;

  assign take        = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_ready_o = state_q == S_IDLE;
  assign fire        = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Locate the index relative to the base. The offset is at most the fill
  // count, so one conditional subtract wraps head plus offset into the ring.
  always_comb begin
    above_base = cmd_i.req.log_index > base_q;
    rel_idx    = cmd_i.req.log_index - base_q - 32'd1;
    in_range   = above_base && (rel_idx < 32'(cnt_q));
    if (!above_base) begin
      keep = '0;
    end else if (in_range) begin
      keep = rel_idx[CntW-1:0];
    end else begin
      keep = cnt_q;
    end
    loc_sum  = (CntW + 1)'(head_q) + (CntW + 1)'(keep);
    loc_wrap = (loc_sum >= WrapSum) ? loc_sum - WrapSum : loc_sum;
    loc_pos  = AddrW'(loc_wrap);
    peek_pos = (tail_q == '0) ? LastPos : tail_q - AddrW'(1);
    unique case (cmd_i.req.action)
      ACT_POP:  rd_addr = head_q;
      ACT_PEEK: rd_addr = peek_pos;
      default:  rd_addr = loc_pos;
    endcase
  end

  assign head_inc = (head_q == LastPos) ? '0 : head_q + AddrW'(1);
  assign tail_inc = (tail_q == LastPos) ? '0 : tail_q + AddrW'(1);
  assign vote_inc = (rd_vote_q == VoteMax) ? rd_vote_q : rd_vote_q + VOTE_WIDTH'(1);

  // Execute step: outcome, ring update and memory writes.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    app_we  = 1'b0;
    vote_we = 1'b0;
    vote_wa = loc_q;
    vote_wd = vote_inc;
    res     = '0;
    res.status = ST_OK;
    unique case (cmd_q.req.action)
      ACT_APPEND: begin
        if (cmd_q.id_zero) begin
          res.status = ST_ZERO_ID;
        end else if (cnt_q >= FullCnt) begin
          res.status = ST_FULL;
        end else begin
          app_we  = 1'b1;
          vote_we = 1'b1;
          vote_wa = tail_q;
          vote_wd = '0;
          tail_d  = tail_inc;
          cnt_d   = cnt_q + CntW'(1);
        end
      end
      ACT_READ: begin
        if (hit_q) begin
          res.out_id      = rd_id_q;
          res.out_payload = 32'(rd_pay_q);
          res.out_votes   = 8'(rd_vote_q);
        end else begin
          res.status = ST_NONE;
        end
      end
      ACT_TRUNC: begin
        cnt_d  = keep_q;
        tail_d = loc_q;
      end
      ACT_POP: begin
        if (cnt_q == '0) begin
          res.status = ST_NONE;
        end else begin
          res.out_id      = rd_id_q;
          res.out_payload = 32'(rd_pay_q);
          res.out_votes   = 8'(rd_vote_q);
          head_d = head_inc;
          cnt_d  = cnt_q - CntW'(1);
          if (base_q != '1) begin
            base_d = base_q + 32'd1;
          end
        end
      end
      ACT_PEEK: begin
        if (cnt_q == '0) begin
          res.status = ST_NONE;
        end else begin
          res.out_id      = rd_id_q;
          res.out_payload = 32'(rd_pay_q);
          res.out_votes   = 8'(rd_vote_q);
        end
      end
      ACT_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        cnt_d  = '0;
      end
      ACT_VOTE: begin
        if (hit_q) begin
          vote_we       = 1'b1;
          res.out_votes = 8'(vote_inc);
        end else begin
          res.status = ST_NONE;
        end
      end
      default: begin
      end
    endcase
    res.entries_held = 11'(cnt_d);
    res.base_now     = base_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire && app_we) begin
      id_mem[tail_q]  <= cmd_q.req.new_id;
      pay_mem[tail_q] <= PAYLOAD_WIDTH'(cmd_q.req.new_payload);
    end
    if (fire && vote_we) begin
      vote_mem[vote_wa] <= vote_wd;
    end
    if (take) begin
      rd_id_q   <= id_mem[rd_addr];
      rd_pay_q  <= pay_mem[rd_addr];
      rd_vote_q <= vote_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q  <= cmd_i;
      hit_q  <= in_range;
      keep_q <= keep;
      loc_q  <= loc_pos;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        state_q <= S_EXEC;
      end else if (fire) begin
        state_q <= S_IDLE;
      end
      if (fire) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        cnt_q       <= cnt_d;
        base_q      <= base_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/rlrt_checker.sv]
// Port-level checks for the log ring table unit, attached by bind.
// Depends on rlrt_pkg and replicated_log_ring_table_unit.
module rlrt_checker import rlrt_pkg::*; #(
  parameter int unsigned LOG_DEPTH = DEF_LOG_DEPTH
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input rlrt_out_t out_data_i
);

  logic        in_xfer, out_xfer;
  logic [2:0]  pending_q;
  logic [31:0] last_base_q;
  logic        seen_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      seen_q      <= 1'b0;
      last_base_q <= '0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   pending_q <= pending_q + 3'd1;
        2'b01:   pending_q <= pending_q - 3'd1;
        default: pending_q <= pending_q;
      endcase
      if (out_xfer) begin
        seen_q      <= 1'b1;
        last_base_q <= out_data_i.base_now;
      end
    end
  end

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  // Every result transfer answers an earlier request transfer.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != 3'd0)
    else $error("result without a pending request");

  // A refused or failed action returns no entry contents.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != ST_OK |->
      out_data_i.out_id == '0 && out_data_i.out_payload == '0 &&
      out_data_i.out_votes == '0)
    else $error("failed action returned entry data");

  // The base only moves forward.
  a_base_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_q |-> out_data_i.base_now >= last_base_q)
    else $error("log base moved backward");

  // The log never reports more entries than the ring holds.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(out_data_i.entries_held) <= LOG_DEPTH)
    else $error("entry count above ring depth");

endmodule

bind replicated_log_ring_table_unit rlrt_checker #(
  .LOG_DEPTH (LOG_DEPTH)
) u_rlrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
